/* rtl/core/aged_address_hash_filter_core_defines.svh */
// Assertion macros for the aged address hash filter core.
// Used by modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef AGED_ADDRESS_HASH_FILTER_CORE_DEFINES_SVH
`define AGED_ADDRESS_HASH_FILTER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define AAHF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aahf check failed");
`define AAHF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aahf check failed");
`else
`define AAHF_ASSERT_SAME(lbl, ante, cons)
`define AAHF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/core/aahf_pkg.sv */
// Shared constants and types of the aged address hash filter core.
// No dependencies.
`timescale 1ns / 1ps
package aahf_pkg;
  localparam int unsigned SLOT_ADDR_W = 24;
  localparam int unsigned TIME_W      = 40;
  localparam int unsigned TTL_W       = 32;
  localparam int unsigned SLOT_OUT_W  = 10;
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam int unsigned TABLE_SLOTS_DEF = 1024;
  localparam int unsigned PROBE_LEN_DEF   = 16;

  localparam logic [31:0]      HASH_MULT = 32'd2654435761;
  localparam logic [TTL_W-1:0] TTL_RESET = 32'd60000;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TEST = 1'b1;

  localparam logic REG_TTL = 1'b0;

  typedef struct packed {
    logic [SLOT_ADDR_W-1:0] addr;
    logic [TIME_W-1:0]      stamp;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);
endpackage

/* rtl/core/aged_address_hash_filter_core.sv */
// A transaction runs from accept through ST_PROBE, which reads k slots (1..PROBE_LEN),
// to ST_DONE and the registered result; an add or a test of address zero skips ST_PROBE.
// One transaction at a time; its probe is paced by the single read port of the
// slot RAM (one slot per cycle). A stalled result holds the next transaction in
// ST_DONE once its probe is over.
// Reset: synchronous; a clearing pass zeroes the slot RAM,
// during which in_stall is high. Time-to-live returns to 60000.
`timescale 1ns / 1ps
`include "aged_address_hash_filter_core_defines.svh"
module aged_address_hash_filter_core #(
  parameter int unsigned TABLE_SLOTS = aahf_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned PROBE_LEN   = aahf_pkg::PROBE_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_op,
  input  logic [aahf_pkg::SLOT_ADDR_W-1:0]    in_address,
  input  logic [aahf_pkg::TIME_W-1:0]         in_now_ms,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_known,
  output logic [aahf_pkg::SLOT_OUT_W-1:0]     out_slot_index,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [aahf_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [aahf_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [aahf_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);
  localparam int unsigned AW = $clog2(TABLE_SLOTS);
  localparam int unsigned PW = $clog2(PROBE_LEN + 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_DONE
  } state_t;

  state_t                              state_r, state_nxt;
  logic [AW-1:0]                       clr_cnt_r, clr_cnt_nxt;
  logic                                op_r, op_nxt;
  logic [aahf_pkg::SLOT_ADDR_W-1:0]    addr_r, addr_nxt;
  logic [aahf_pkg::TIME_W-1:0]         now_r, now_nxt;
  logic [AW-1:0]                       home_r, home_nxt;
  logic [PW-1:0]                       issue_r, issue_nxt;
  logic                                rd_pend_r, rd_pend_nxt;
  logic [PW-1:0]                       rd_off_r, rd_off_nxt;
  logic                                res_known_r, res_known_nxt;
  logic [AW-1:0]                       res_slot_r, res_slot_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic                                out_known_r, out_known_nxt;
  logic [aahf_pkg::SLOT_OUT_W-1:0]     out_slot_r, out_slot_nxt;
  logic [aahf_pkg::TTL_W-1:0]          ttl_r, ttl_nxt;

  logic                                ram_wr_en;
  logic [AW-1:0]                       ram_wr_addr;
  aahf_pkg::entry_t                    ram_wr_entry;
  logic                                ram_rd_en;
  logic [AW-1:0]                       ram_rd_addr;
  logic [aahf_pkg::ENTRY_W-1:0]        ram_rd_data;
  aahf_pkg::entry_t                    rd_entry;

  logic [31:0]                         hash_prod;
  logic [AW-1:0]                       rd_idx;
  logic                                slot_match;
  logic                                slot_empty;
  logic [aahf_pkg::TIME_W-1:0]         age;
  logic                                expired;
  logic                                last_probe;
  logic                                issue_ok;
  logic                                in_accept;
  logic                                cfg_wr;

  aahf_ram #(
    .WIDTH (aahf_pkg::ENTRY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_entry),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign rd_entry   = aahf_pkg::entry_t'(ram_rd_data);
  assign hash_prod  = 32'(in_address) * aahf_pkg::HASH_MULT;
  assign rd_idx     = home_r + AW'(rd_off_r);
  assign slot_match = (rd_entry.addr == addr_r);
  assign slot_empty = (rd_entry.addr == '0);
  assign age        = (now_r >= rd_entry.stamp) ? (now_r - rd_entry.stamp) : '0;
  assign expired    = (age > aahf_pkg::TIME_W'(ttl_r));
  assign last_probe = (rd_off_r == PW'(PROBE_LEN - 1));
  assign issue_ok   = (state_r == ST_PROBE) && (issue_r < PW'(PROBE_LEN));

  assign in_stall   = (state_r != ST_IDLE);
  assign in_accept  = in_valid && !in_stall;

  assign out_valid      = out_valid_r;
  assign out_known      = out_known_r;
  assign out_slot_index = out_slot_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[aahf_pkg::CFG_ADDR_W-1] == aahf_pkg::REG_TTL) ?
                      ttl_r : '0;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    op_nxt        = op_r;
    addr_nxt      = addr_r;
    now_nxt       = now_r;
    home_nxt      = home_r;
    issue_nxt     = issue_r;
    rd_pend_nxt   = rd_pend_r;
    rd_off_nxt    = rd_off_r;
    res_known_nxt = res_known_r;
    res_slot_nxt  = res_slot_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_known_nxt = out_known_r;
    out_slot_nxt  = out_slot_r;
    ttl_nxt       = ttl_r;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = clr_cnt_r;
    ram_wr_entry  = '0;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = home_r + AW'(issue_r);

    if (cfg_wr && (cfg_paddr[aahf_pkg::CFG_ADDR_W-1] == aahf_pkg::REG_TTL)) begin
      ttl_nxt = cfg_pwdata;
    end

    case (state_r)
      ST_CLEAR: begin
        ram_wr_en   = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          op_nxt        = in_op;
          addr_nxt      = in_address;
          now_nxt       = in_now_ms;
          home_nxt      = hash_prod[AW-1:0];
          issue_nxt     = '0;
          rd_pend_nxt   = 1'b0;
          res_known_nxt = 1'b0;
          res_slot_nxt  = '0;
          state_nxt     = (in_address == '0) ? ST_DONE : ST_PROBE;
        end
      end
      ST_PROBE: begin
        ram_rd_en   = issue_ok;
        rd_pend_nxt = issue_ok;
        rd_off_nxt  = issue_r;
        if (issue_ok) begin
          issue_nxt = issue_r + 1'b1;
        end
        if (rd_pend_r) begin
          if (op_r == aahf_pkg::OP_ADD) begin
            if (slot_match || slot_empty || expired || last_probe) begin
              ram_wr_en          = 1'b1;
              ram_wr_addr        = (slot_match || slot_empty || expired) ? rd_idx : home_r;
              ram_wr_entry.addr  = addr_r;
              ram_wr_entry.stamp = now_r;
              res_slot_nxt       = ram_wr_addr;
              res_known_nxt      = 1'b0;
              rd_pend_nxt        = 1'b0;
              state_nxt          = ST_DONE;
            end
          end else begin
            if (slot_match) begin
              res_known_nxt = !expired;
              res_slot_nxt  = rd_idx;
              rd_pend_nxt   = 1'b0;
              state_nxt     = ST_DONE;
            end else if (slot_empty || last_probe) begin
              res_known_nxt = 1'b0;
              res_slot_nxt  = '0;
              rd_pend_nxt   = 1'b0;
              state_nxt     = ST_DONE;
            end
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_known_nxt = res_known_r;
          out_slot_nxt  = aahf_pkg::SLOT_OUT_W'(res_slot_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      issue_r     <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      ttl_r       <= aahf_pkg::TTL_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      issue_r     <= issue_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
      ttl_r       <= ttl_nxt;
      op_r        <= op_nxt;
      addr_r      <= addr_nxt;
      now_r       <= now_nxt;
      home_r      <= home_nxt;
      rd_off_r    <= rd_off_nxt;
      res_known_r <= res_known_nxt;
      res_slot_r  <= res_slot_nxt;
      out_known_r <= out_known_nxt;
      out_slot_r  <= out_slot_nxt;
    end
  end

  `AAHF_ASSERT_NEXT(a_accept_stalls, in_accept, in_stall)
  `AAHF_ASSERT_SAME(a_clear_quiet, state_r == ST_CLEAR, in_stall && !out_valid_r)
  `AAHF_ASSERT_SAME(a_wr_when_allowed, ram_wr_en, state_r == ST_CLEAR || state_r == ST_PROBE)
  `AAHF_ASSERT_SAME(a_rd_off_range, rd_pend_r, rd_off_r < PW'(PROBE_LEN))
  `AAHF_ASSERT_SAME(a_known_only_test, state_r == ST_DONE && res_known_r, op_r == aahf_pkg::OP_TEST)
endmodule

/* rtl/core/aahf_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
module aahf_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
